>>> hw/rtl/stt_pkg.sv
// shared types, codes and score helpers of the search transposition table
package stt_pkg;

  // request function codes as they arrive on the input word
  localparam logic [1:0] FUNC_STORE = 2'd0;
  localparam logic [1:0] FUNC_PROBE = 2'd1;
  localparam logic [1:0] FUNC_FETCH = 2'd2;

  // bound codes kept with each entry
  localparam logic [1:0] BOUND_EXACT = 2'd0;
  localparam logic [1:0] BOUND_LOWER = 2'd1;
  localparam logic [1:0] BOUND_UPPER = 2'd2;

  // distance of the mate threshold below the mate score
  localparam int MateMargin = 1000;

  typedef enum logic [1:0] {
    OP_STORE,
    OP_PROBE,
    OP_FETCH,
    OP_NONE
  } op_e;

  // classified request passed from the front end to the back end
  typedef struct packed {
    op_e                op;
    logic [63:0]        key;
    logic signed [7:0]  depth;
    logic [7:0]         ply;
    logic signed [15:0] score;
    logic [1:0]         bound;
    logic               move_valid;
    logic signed [15:0] alpha;
    logic signed [15:0] beta;
  } req_t;

  // one table slot, the move field is kept beside it
  typedef struct packed {
    logic [63:0]        key;
    logic signed [7:0]  depth;
    logic signed [15:0] score;
    logic [1:0]         bound;
    logic               move_valid;
  } entry_t;

  // mate score shift by ply with 16-bit saturation
  // to_node: root-relative to node-relative, else the reverse
  function automatic logic signed [15:0] mate_adjust(
    input logic signed [15:0] s,
    input logic [7:0]         p,
    input logic signed [15:0] lim,
    input logic               to_node
  );
    logic signed [17:0] s18;
    logic signed [17:0] p18;
    logic signed [17:0] lim18;
    logic signed [17:0] sum;
    logic               pos;
    logic               neg;
    logic               add;
    logic               sub;
    s18   = {{2{s[15]}}, s};
    p18   = {10'b0, p};
    lim18 = {{2{lim[15]}}, lim};
    pos   = s18 > lim18;
    neg   = s18 < -lim18;
    add   = to_node ? pos : neg;
    sub   = to_node ? neg : pos;
    if (add) begin
      sum = s18 + p18;
    end else if (sub) begin
      sum = s18 - p18;
    end else begin
      sum = s18;
    end
    if (sum > 18'sd32767) begin
      mate_adjust = 16'sh7fff;
    end else if (sum < -18'sd32768) begin
      mate_adjust = 16'sh8000;
    end else begin
      mate_adjust = sum[15:0];
    end
  endfunction

endpackage

>>> hw/rtl/search_transposition_table.sv
// top level of the search transposition table: front end, queue, back end
//
//   port group  direction  handshake                 payload
//   request     in         in_valid_i / in_stall_o   func_i .. beta_i
//   response    out        out_valid_o / out_stall_i hit_o .. found_move_o
//
// a request passes the back end in order: memory read when it is taken, then
// evaluate and write back, so the back end takes no new request until it is
// through with the last; each request reads one slot, a store may write it back
// after reset the table is swept to zero, slot by slot, with
// in_stall_o high the whole time
// a held response only stops the back end; the two-word queue keeps taking
// requests until it fills
module search_transposition_table import stt_pkg::*; #(
  parameter int INDEX_BITS = 16,
  parameter int MOVE_BITS  = 16,
  parameter int MATE_SCORE = 32000
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // request word
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [1:0]             func_i,
  input  logic [63:0]            position_hash_i,
  input  logic signed [7:0]      search_depth_i,
  input  logic [7:0]             ply_i,
  input  logic signed [15:0]     score_i,
  input  logic [1:0]             bound_kind_i,
  input  logic                   move_valid_i,
  input  logic [MOVE_BITS-1:0]   best_move_i,
  input  logic signed [15:0]     alpha_i,
  input  logic signed [15:0]     beta_i,
  // response word
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic                   hit_o,
  output logic                   cutoff_o,
  output logic signed [15:0]     cutoff_score_o,
  output logic signed [15:0]     new_alpha_o,
  output logic signed [15:0]     new_beta_o,
  output logic                   found_move_valid_o,
  output logic [MOVE_BITS-1:0]   found_move_o
);

  // queue between the two halves, wide enough for a request and its move
  localparam int QueueDepth = 2;
  localparam int ReqBits    = $bits(req_t);
  localparam int QueueBits  = ReqBits + MOVE_BITS;

  logic                 push;
  logic                 pop;
  logic                 q_full;
  logic                 q_empty;
  logic                 clearing;
  req_t                 front_req;
  logic [MOVE_BITS-1:0] front_move;
  logic [QueueBits-1:0] q_head;
  req_t                 head_req;
  logic [MOVE_BITS-1:0] head_move;

  // classify the incoming word and turn a store score node-relative
  stt_front #(
    .MOVE_BITS (MOVE_BITS),
    .MATE_SCORE(MATE_SCORE)
  ) u_front (
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .func_i         (func_i),
    .position_hash_i(position_hash_i),
    .search_depth_i (search_depth_i),
    .ply_i          (ply_i),
    .score_i        (score_i),
    .bound_kind_i   (bound_kind_i),
    .move_valid_i   (move_valid_i),
    .best_move_i    (best_move_i),
    .alpha_i        (alpha_i),
    .beta_i         (beta_i),
    .queue_full_i   (q_full),
    .clearing_i     (clearing),
    .push_o         (push),
    .req_o          (front_req),
    .move_o         (front_move)
  );

  stt_queue #(
    .WIDTH(QueueBits),
    .DEPTH(QueueDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .wdata_i({front_move, front_req}),
    .full_o (q_full),
    .pop_i  (pop),
    .empty_o(q_empty),
    .rdata_o(q_head)
  );

  assign head_req  = req_t'(q_head[ReqBits-1:0]);
  assign head_move = q_head[QueueBits-1:ReqBits];

  // table memory and request execution
  stt_back #(
    .INDEX_BITS(INDEX_BITS),
    .MOVE_BITS (MOVE_BITS),
    .MATE_SCORE(MATE_SCORE)
  ) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .empty_i           (q_empty),
    .head_i            (head_req),
    .head_move_i       (head_move),
    .pop_o             (pop),
    .clearing_o        (clearing),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .hit_o             (hit_o),
    .cutoff_o          (cutoff_o),
    .cutoff_score_o    (cutoff_score_o),
    .new_alpha_o       (new_alpha_o),
    .new_beta_o        (new_beta_o),
    .found_move_valid_o(found_move_valid_o),
    .found_move_o      (found_move_o)
  );

endmodule

>>> hw/rtl/stt_front.sv
// front end: takes request words, classifies them, prepares store scores
module stt_front import stt_pkg::*; #(
  parameter int MOVE_BITS  = 16,
  parameter int MATE_SCORE = 32000
) (
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [1:0]             func_i,
  input  logic [63:0]            position_hash_i,
  input  logic signed [7:0]      search_depth_i,
  input  logic [7:0]             ply_i,
  input  logic signed [15:0]     score_i,
  input  logic [1:0]             bound_kind_i,
  input  logic                   move_valid_i,
  input  logic [MOVE_BITS-1:0]   best_move_i,
  input  logic signed [15:0]     alpha_i,
  input  logic signed [15:0]     beta_i,
  input  logic                   queue_full_i,
  input  logic                   clearing_i,
  output logic                   push_o,
  output req_t                   req_o,
  output logic [MOVE_BITS-1:0]   move_o
);

  localparam logic signed [15:0] MateLimit = 16'(MATE_SCORE - MateMargin);

  op_e op;

  always_comb begin
    case (func_i)
      FUNC_STORE: op = OP_STORE;
      FUNC_PROBE: op = OP_PROBE;
      FUNC_FETCH: op = OP_FETCH;
      default:    op = OP_NONE;
    endcase
  end

  assign in_stall_o = queue_full_i | clearing_i;
  assign push_o     = in_valid_i & ~in_stall_o;

  always_comb begin
    req_o.op         = op;
    req_o.key        = position_hash_i;
    req_o.depth      = search_depth_i;
    req_o.ply        = ply_i;
    // only stores use the score, turned node-relative here
    req_o.score      = mate_adjust(score_i, ply_i, MateLimit, 1'b1);
    req_o.bound      = bound_kind_i;
    req_o.move_valid = move_valid_i;
    req_o.alpha      = alpha_i;
    req_o.beta       = beta_i;
  end

  assign move_o = move_valid_i ? best_move_i : '0;

endmodule

>>> hw/rtl/stt_queue.sv
// small register fifo between front end and back end
module stt_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [WIDTH-1:0] rdata_o
);

  localparam int PtrBits = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntBits = $clog2(DEPTH + 1);
  localparam logic [PtrBits-1:0] LastPtr = PtrBits'(DEPTH - 1);
  localparam logic [CntBits-1:0] FullCnt = CntBits'(DEPTH);

  logic [WIDTH-1:0]   slot_q [DEPTH];
  logic [PtrBits-1:0] wptr_q, wptr_d;
  logic [PtrBits-1:0] rptr_q, rptr_d;
  logic [CntBits-1:0] cnt_q, cnt_d;
  logic               do_push;
  logic               do_pop;

  assign full_o  = cnt_q == FullCnt;
  assign empty_o = cnt_q == '0;
  assign rdata_o = slot_q[rptr_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == LastPtr) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == LastPtr) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wptr_q] <= wdata_i;
    end
  end

endmodule

>>> hw/rtl/stt_back.sv
// back end: table memory, clearing pass and request execution
module stt_back import stt_pkg::*; #(
  parameter int INDEX_BITS = 16,
  parameter int MOVE_BITS  = 16,
  parameter int MATE_SCORE = 32000
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   empty_i,
  input  req_t                   head_i,
  input  logic [MOVE_BITS-1:0]   head_move_i,
  output logic                   pop_o,
  output logic                   clearing_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic                   hit_o,
  output logic                   cutoff_o,
  output logic signed [15:0]     cutoff_score_o,
  output logic signed [15:0]     new_alpha_o,
  output logic signed [15:0]     new_beta_o,
  output logic                   found_move_valid_o,
  output logic [MOVE_BITS-1:0]   found_move_o
);

  localparam int SlotCount = 1 << INDEX_BITS;
  localparam int EntBits   = $bits(entry_t);
  localparam int RowBits   = EntBits + MOVE_BITS;
  localparam logic signed [15:0] MateLimit = 16'(MATE_SCORE - MateMargin);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EVAL
  } state_e;

  state_e state_q;

  logic [RowBits-1:0]    mem [SlotCount];
  logic [RowBits-1:0]    rd_q;
  logic [INDEX_BITS-1:0] clr_q;
  req_t                  req_q;
  logic [MOVE_BITS-1:0]  move_q;

  logic                  out_valid_q;
  logic                  hit_q, cutoff_q, fmv_q;
  logic signed [15:0]    cscore_q, alpha_q, beta_q;
  logic [MOVE_BITS-1:0]  fmove_q;

  logic                  mem_we;
  logic [INDEX_BITS-1:0] mem_wa;
  logic [RowBits-1:0]    mem_wd;
  logic                  mem_re;

  entry_t                ent;
  logic [MOVE_BITS-1:0]  ent_move;
  logic                  key_eq;
  logic                  replace;
  logic                  probe_hit;
  logic                  out_free;
  logic                  finish;
  logic signed [15:0]    root_score;
  logic signed [15:0]    pa, pb;
  logic                  pcut;
  entry_t                new_ent;

  logic                  hit_d, cutoff_d, fmv_d;
  logic signed [15:0]    cscore_d, alpha_d, beta_d;
  logic [MOVE_BITS-1:0]  fmove_d;

  assign ent        = entry_t'(rd_q[EntBits-1:0]);
  assign ent_move   = rd_q[RowBits-1:EntBits];
  assign key_eq     = ent.key == req_q.key;
  assign replace    = !key_eq || (req_q.depth >= ent.depth);
  assign probe_hit  = key_eq && (ent.depth >= req_q.depth);
  assign root_score = mate_adjust(ent.score, req_q.ply, MateLimit, 1'b0);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign finish     = (state_q == ST_EVAL) && out_free;
  assign pop_o      = (state_q == ST_IDLE) && !empty_i;
  assign mem_re     = pop_o;
  assign clearing_o = state_q == ST_CLEAR;

  // bound tightening for a probe hit
  always_comb begin
    pa   = req_q.alpha;
    pb   = req_q.beta;
    pcut = 1'b0;
    case (ent.bound)
      BOUND_EXACT: pcut = 1'b1;
      BOUND_LOWER: if (root_score > req_q.alpha) pa = root_score;
      BOUND_UPPER: if (root_score < req_q.beta) pb = root_score;
      default: ;
    endcase
    if (ent.bound != BOUND_EXACT) begin
      pcut = pa >= pb;
    end
  end

  always_comb begin
    hit_d    = 1'b0;
    cutoff_d = 1'b0;
    cscore_d = '0;
    alpha_d  = req_q.alpha;
    beta_d   = req_q.beta;
    fmv_d    = 1'b0;
    fmove_d  = '0;
    case (req_q.op)
      OP_PROBE: begin
        if (probe_hit) begin
          hit_d    = 1'b1;
          cutoff_d = pcut;
          cscore_d = root_score;
          alpha_d  = pa;
          beta_d   = pb;
        end
      end
      OP_FETCH: begin
        if (key_eq) begin
          hit_d = 1'b1;
          if (ent.move_valid) begin
            fmv_d   = 1'b1;
            fmove_d = ent_move;
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    new_ent.key        = req_q.key;
    new_ent.depth      = req_q.depth;
    new_ent.score      = req_q.score;
    new_ent.bound      = req_q.bound;
    new_ent.move_valid = req_q.move_valid;
    if (state_q == ST_CLEAR) begin
      mem_we = 1'b1;
      mem_wa = clr_q;
      mem_wd = '0;
    end else begin
      mem_we = finish && (req_q.op == OP_STORE) && replace;
      mem_wa = req_q.key[INDEX_BITS-1:0];
      mem_wd = {move_q, new_ent};
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_q <= mem[head_i.key[INDEX_BITS-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      req_q  <= head_i;
      move_q <= head_move_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      hit_q       <= 1'b0;
      cutoff_q    <= 1'b0;
      cscore_q    <= '0;
      alpha_q     <= '0;
      beta_q      <= '0;
      fmv_q       <= 1'b0;
      fmove_q     <= '0;
    end else begin
      if (finish) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == '1) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (!empty_i) begin
            state_q <= ST_EVAL;
          end
        end
        ST_EVAL: begin
          if (out_free) begin
            hit_q       <= hit_d;
            cutoff_q    <= cutoff_d;
            cscore_q    <= cscore_d;
            alpha_q     <= alpha_d;
            beta_q      <= beta_d;
            fmv_q       <= fmv_d;
            fmove_q     <= fmove_d;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o        = out_valid_q;
  assign hit_o              = hit_q;
  assign cutoff_o           = cutoff_q;
  assign cutoff_score_o     = cscore_q;
  assign new_alpha_o        = alpha_q;
  assign new_beta_o         = beta_q;
  assign found_move_valid_o = fmv_q;
  assign found_move_o       = fmove_q;

endmodule
